FILE: hw/rtl/cht_pkg.sv
// shared constants and controller/datapath interface types for the chained hash table
package cht_pkg;

  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  // key is reduced modulo the bucket count by a reciprocal multiply
  localparam int MOD_STEPS = 2;
  localparam int MOD_CW    = $clog2(MOD_STEPS);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                load;
    logic                mod_step;
    logic                fill_rd;
    logic                clr_wr;
    logic                ins_wr;
    logic                scan_init;
    logic                scan_rd;
    logic                scan_dec;
    logic                sh_rd;
    logic                sh_wr;
    logic                fill_dec;
    logic                set_res;
    logic [STATUS_W-1:0] res_code;
    logic                res_take_val;
    logic                out_load;
  } cht_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            mod_last;
    logic            clr_last;
    logic            fill_full;
    logic            fill_zero;
    logic            key_hit;
    logic            idx_zero;
    logic            shift_done;
    logic            out_free;
  } cht_sts_t;

endpackage

FILE: hw/rtl/chained_hash_table.sv
// top level of the chained hash table: controller plus datapath
// Key-value table with NUM_BUCKETS buckets of SLOTS_PER_BUCKET entries each.
// in channel: one transaction per operation; in_tuser holds the opcode
// (insert, search, delete), in_tdata the key and the value.
// out channel: exactly one transaction per operation; out_tuser holds the
// status (ok, not found, bucket full), out_tdata the found value or zero.
// Operations are handled one at a time. The key is reduced modulo the
// bucket count by a reciprocal multiply, then the bucket fill is read.
// Search and delete compare one entry at a time (one entry memory read
// port, newest first), and a delete moves each newer entry down to close the gap.
// After reset the fill memory is swept to zero bucket by bucket, during
// which in_tready stays low. Results sit in an output register: a new
// operation is accepted while a result waits, but the next result is held
// back until out_tready takes the one in front of it.
module chained_hash_table #(
  parameter int NUM_BUCKETS      = 16,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cht_pkg::IN_TDATA_W-1:0]   in_tdata,   // key[30:0], value[62:31], zero[63]
  input  logic [cht_pkg::OP_W-1:0]         in_tuser,   // opcode[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cht_pkg::OUT_TDATA_W-1:0]  out_tdata,  // found_value[31:0]
  output logic [cht_pkg::STATUS_W-1:0]     out_tuser   // status[1:0]
);
  import cht_pkg::*;

  cht_cmd_t cmd;
  cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cht_dpath #(
    .NUM_BUCKETS      (NUM_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hw/rtl/cht_ctrl.sv
// controller state machine sequencing each hash table operation
module cht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cht_pkg::cht_sts_t sts,
  output cht_pkg::cht_cmd_t cmd
);
  import cht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_FILL_RD,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SH_RD,
    S_SH_WR,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_FILL_RD;
      end
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_RESULT;
        if (sts.op == OP_INSERT) begin
          if (sts.fill_full) begin
            cmd.res_code = ST_FULL;
          end else begin
            cmd.ins_wr   = 1'b1;
            cmd.res_code = ST_OK;
          end
        end else if ((sts.op == OP_SEARCH || sts.op == OP_DELETE) && !sts.fill_zero) begin
          cmd.set_res   = 1'b0;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_RD;
        end else begin
          cmd.res_code = ST_MISS;
        end
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.key_hit) begin
          if (sts.op == OP_SEARCH) begin
            cmd.set_res      = 1'b1;
            cmd.res_code     = ST_OK;
            cmd.res_take_val = 1'b1;
            state_nxt        = S_RESULT;
          end else begin
            state_nxt = S_SHIFT_CHK;
          end
        end else if (sts.idx_zero) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_MISS;
          state_nxt    = S_RESULT;
        end else begin
          cmd.scan_dec = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_SHIFT_CHK: begin
        if (sts.shift_done) begin
          cmd.fill_dec = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          state_nxt    = S_RESULT;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.sh_rd = 1'b1;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHIFT_CHK;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/cht_dpath.sv
// datapath: bucket reduction, entry and fill memories, scan and shift registers, output register
module cht_dpath #(
  parameter int NUM_BUCKETS      = 16,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cht_pkg::cht_cmd_t                cmd,
  output cht_pkg::cht_sts_t                sts,
  input  logic [cht_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [cht_pkg::OP_W-1:0]         in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cht_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [cht_pkg::STATUS_W-1:0]     out_tuser
);
  import cht_pkg::*;

  localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW    = $clog2(TOTAL);
  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);

  // reciprocal of the bucket count, exact for every 31-bit key
  localparam int              RECIP_S    = KEY_W + BW;
  localparam int              PROD_W     = 2 * KEY_W + 1;
  localparam longint unsigned RECIP_WIDE =
      ((64'd1 << RECIP_S) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [KEY_W:0]  RECIP_M    = (KEY_W + 1)'(RECIP_WIDE);
  localparam logic [BW-1:0]   NB_LO      = BW'(NUM_BUCKETS);

  localparam logic [AW-1:0] SLOTS_A = AW'(SLOTS_PER_BUCKET);
  localparam logic [FW-1:0] SLOTS_F = FW'(SLOTS_PER_BUCKET);
  localparam logic [BW-1:0] LAST_B  = BW'(NUM_BUCKETS - 1);

  // latched transaction
  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  // modulo reduction
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  quot, quot_r;
  logic [BW-1:0]     qd_lo;
  logic [BW-1:0]     bucket_r, bucket_nxt;
  logic [MOD_CW-1:0] mod_cnt_r;

  // memories and their read registers
  logic [KEY_W-1:0] key_mem [TOTAL];
  logic [VAL_W-1:0] val_mem [TOTAL];
  logic [FW-1:0]    fill_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [FW-1:0]    fill_q;

  logic [FW-1:0] idx_r;
  logic [FW-1:0] idx_inc;
  logic [BW-1:0] clr_cnt_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [VAL_W-1:0]    res_value_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_value_r;

  logic [AW-1:0]    base_a;
  logic             ent_we, ent_re;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [KEY_W-1:0] wr_key;
  logic [VAL_W-1:0] wr_val;
  logic             fill_we;
  logic [BW-1:0]    fill_wa;
  logic [FW-1:0]    fill_wd;

  // first step registers the quotient, second step the remainder
  // the remainder is below the bucket count, so its low bits are enough
  assign prod       = PROD_W'(key_r) * PROD_W'(RECIP_M);
  assign quot       = KEY_W'(prod >> RECIP_S);
  assign qd_lo      = quot_r[BW-1:0] * NB_LO;
  assign bucket_nxt = key_r[BW-1:0] - qd_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
    end else if (cmd.load) begin
      mod_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_tuser;
      key_r    <= in_tdata[KEY_W-1:0];
      val_r    <= in_tdata[KEY_W+VAL_W-1:KEY_W];
    end else if (cmd.mod_step) begin
      quot_r   <= quot;
      bucket_r <= bucket_nxt;
    end
  end

  assign base_a  = AW'(bucket_r) * SLOTS_A;
  assign idx_inc = idx_r + 1'b1;

  assign ent_we  = cmd.ins_wr | cmd.sh_wr;
  assign wr_addr = cmd.ins_wr ? (base_a + AW'(fill_q)) : (base_a + AW'(idx_r));
  assign wr_key  = cmd.ins_wr ? key_r : key_q;
  assign wr_val  = cmd.ins_wr ? val_r : val_q;
  assign ent_re  = cmd.scan_rd | cmd.sh_rd;
  assign rd_addr = cmd.sh_rd ? (base_a + AW'(idx_inc)) : (base_a + AW'(idx_r));

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (ent_re) begin
      key_q <= key_mem[rd_addr];
      val_q <= val_mem[rd_addr];
    end
  end

  assign fill_we = cmd.clr_wr | cmd.ins_wr | cmd.fill_dec;
  assign fill_wa = cmd.clr_wr ? clr_cnt_r : bucket_r;

  always_comb begin
    if (cmd.clr_wr) begin
      fill_wd = '0;
    end else if (cmd.ins_wr) begin
      fill_wd = fill_q + 1'b1;
    end else begin
      fill_wd = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (cmd.fill_rd) fill_q <= fill_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // scan runs newest to oldest; the shift walks back up towards the fill
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx_r <= fill_q - 1'b1;
    end else if (cmd.scan_dec) begin
      idx_r <= idx_r - 1'b1;
    end else if (cmd.sh_wr) begin
      idx_r <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_value_r  <= cmd.res_take_val ? val_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  assign sts.op         = op_r;
  assign sts.mod_last   = (mod_cnt_r == MOD_CW'(MOD_STEPS - 1));
  assign sts.clr_last   = (clr_cnt_r == LAST_B);
  assign sts.fill_full  = (fill_q >= SLOTS_F);
  assign sts.fill_zero  = (fill_q == '0);
  assign sts.key_hit    = (key_q == key_r);
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.shift_done = (idx_inc == fill_q);
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

FILE: tb/tb_chained_hash_table.sv
// self-checking testbench for the chained hash table: directed and random operations
module tb_chained_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  import cht_pkg::*;

  localparam int NB          = 16;
  localparam int SLOTS       = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 64;
  localparam int MAX_REPORTS = 50;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    value;
  } op_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  // shadow of the table contents, updated as each transaction is accepted
  logic [KEY_W-1:0] tbl_key [NB][SLOTS];
  logic [VAL_W-1:0] tbl_val [NB][SLOTS];
  int               tbl_fill [NB];

  op_result_t pending_results[$];

  int     errors      = 0;
  int     n_sent      = 0;
  int     n_checked   = 0;
  int     n_found     = 0;
  int     n_miss      = 0;
  int     n_refused   = 0;
  longint cycle_count = 0;
  bit     tx_idle     = 1'b1;
  bit     rx_idle     = 1'b1;
  int     rx_hold     = 0;

  chained_hash_table #(
    .NUM_BUCKETS     (NB),
    .SLOTS_PER_BUCKET(SLOTS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("tb_chained_hash_table: FAIL");
    $finish;
  end

  function automatic int newest_slot(int b, logic [KEY_W-1:0] key);
    for (int i = tbl_fill[b] - 1; i >= 0; i--)
      if (tbl_key[b][i] == key) return i;
    return -1;
  endfunction

  function automatic op_result_t table_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] val);
    op_result_t r;
    int         b;
    int         hit;
    r.status = ST_MISS;
    r.value  = '0;
    b        = int'(key % NB);
    hit      = newest_slot(b, key);
    case (op)
      OP_INSERT: begin
        if (tbl_fill[b] >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          tbl_key[b][tbl_fill[b]] = key;
          tbl_val[b][tbl_fill[b]] = val;
          tbl_fill[b]++;
          r.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          r.status = ST_OK;
          r.value  = tbl_val[b][hit];
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          // close the gap left by the removed entry
          for (int i = hit; i < tbl_fill[b] - 1; i++) begin
            tbl_key[b][i] = tbl_key[b][i+1];
            tbl_val[b][i] = tbl_val[b][i+1];
          end
          tbl_fill[b]--;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_in_bucket(int b);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    return KEY_W'(k - (k % NB) + b);
  endfunction

  // some key currently held in the table, or a random one if it is empty
  function automatic logic [KEY_W-1:0] live_key();
    int total;
    int pick;
    total = 0;
    foreach (tbl_fill[b]) total += tbl_fill[b];
    if (total == 0) return KEY_W'($urandom);
    pick = $urandom_range(0, total - 1);
    foreach (tbl_fill[b]) begin
      if (pick < tbl_fill[b]) return tbl_key[b][pick];
      pick -= tbl_fill[b];
    end
    return '0;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // leaves in_tvalid high on return; stop_sending drops it
  task automatic send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    int         gap;
    op_result_t r;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val, key};
    do @(posedge clk); while (!in_tready);
    r = table_apply(op, key, val);
    pending_results.push_back(r);
    n_sent++;
    if (op == OP_SEARCH && r.status == ST_OK) n_found++;
    if (r.status == ST_MISS) n_miss++;
    if (r.status == ST_FULL) n_refused++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_op();
    int               r;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_INSERT;
    else if (r < 65) op = OP_SEARCH;
    else if (r < 95) op = OP_DELETE;
    else op = OP_UNUSED;
    if (op == OP_INSERT)
      key = $urandom_range(0, 1) ? live_key() : key_in_bucket($urandom_range(0, NB - 1));
    else
      key = ($urandom_range(0, 3) != 0) ? live_key() : KEY_W'($urandom);
    send_op(op, key, $urandom);
  endtask

  task automatic test_directed();
    send_op(OP_SEARCH, 31'd5, 32'h0);
    send_op(OP_DELETE, 31'd5, 32'h0);
    send_op(OP_INSERT, 31'd0, 32'h8000_0000);
    send_op(OP_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_SEARCH, 31'd0, 32'h0);
    send_op(OP_SEARCH, 31'h7FFF_FFFF, 32'h0);
    send_op(OP_UNUSED, 31'd0, 32'hFFFF_FFFF);
    // fill one bucket with a duplicate among its keys
    send_op(OP_INSERT, 31'd5, 32'd1);
    send_op(OP_INSERT, 31'd21, 32'd2);
    send_op(OP_INSERT, 31'd5, 32'd3);
    send_op(OP_INSERT, 31'd37, 32'd4);
    send_op(OP_INSERT, 31'd53, 32'd5);
    send_op(OP_SEARCH, 31'd5, 32'h0);
    send_op(OP_SEARCH, 31'd21, 32'h0);
    send_op(OP_DELETE, 31'd5, 32'h0);
    send_op(OP_SEARCH, 31'd5, 32'h0);
    send_op(OP_SEARCH, 31'd37, 32'h0);
    // oldest entry goes, two newer ones move down
    send_op(OP_DELETE, 31'd5, 32'h0);
    send_op(OP_SEARCH, 31'd5, 32'h0);
    send_op(OP_DELETE, 31'd21, 32'h0);
    send_op(OP_DELETE, 31'd37, 32'h0);
    send_op(OP_SEARCH, 31'd69, 32'h0);
    send_op(OP_DELETE, 31'd0, 32'h0);
    send_op(OP_DELETE, 31'h7FFF_FFFF, 32'h0);
    wait_drain();
  endtask

  task automatic test_bucket_sequences();
    logic [KEY_W-1:0] keys [SLOTS+1];
    int               b;
    int               n;
    int               j;
    repeat (30) begin
      b = $urandom_range(0, NB - 1);
      n = $urandom_range(1, SLOTS + 1);
      for (int i = 0; i < n; i++) begin
        keys[i] = (i > 0 && $urandom_range(0, 3) == 0) ? keys[$urandom_range(0, i - 1)]
                                                        : key_in_bucket(b);
        send_op(OP_INSERT, keys[i], $urandom);
      end
      for (int i = 0; i < n; i++) send_op(OP_SEARCH, keys[i], $urandom);
      // remove in random order, looking each key up again afterwards
      for (int i = n; i > 0; i--) begin
        j = $urandom_range(0, i - 1);
        send_op(OP_DELETE, keys[j], $urandom);
        send_op(OP_SEARCH, keys[j], $urandom);
        keys[j] = keys[i-1];
      end
    end
    wait_drain();
  endtask

  task automatic test_random_mix();
    repeat (750) send_random_op();
    wait_drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    repeat (40) send_random_op();
    wait_drain();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (60) send_random_op();
      wait_drain();
    end
  endtask

  task automatic test_no_idle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (300) send_random_op();
    wait_drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid && rx_hold == 0);
    end
  end

  always @(posedge clk) begin : check_results
    op_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: status %0d value %h",
                                  out_tuser, out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", out_tuser, want.status));
        if (out_tdata !== want.value)
          report_mismatch($sformatf("value %h, wanted %h", out_tdata, want.value));
      end
    end
  end

  initial begin
    foreach (tbl_fill[b]) tbl_fill[b] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_bucket_sequences();
    test_random_mix();
    test_backpressure();
    test_drain_pause();
    test_no_idle();

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d operations: %0d searches hit, %0d misses, %0d inserts refused as full",
             n_sent, n_found, n_miss, n_refused);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0) $display("tb_chained_hash_table: PASS");
    else $display("tb_chained_hash_table: FAIL");
    $finish;
  end

endmodule
